// ===== hdl/sbusfr_pkg.sv =====
// Package: shared types, constants and helpers for the serial RC frame receiver.
package sbusfr_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int POS_W        = $clog2(FRAME_BYTES);
    localparam int DATA_BYTES   = FRAME_BYTES - 3;
    localparam int FLAG_POS     = FRAME_BYTES - 2;
    localparam int NUM_ANALOG   = 16;
    localparam int CH_BITS      = 11;
    localparam int DATA_W       = 8 * DATA_BYTES;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
    localparam logic [7:0]  HEADER_BYTE   = 8'h0F;
    localparam logic [15:0] GAP_RESET     = 16'd3500;
    localparam logic [10:0] DIGITAL_LOW   = 11'd173;
    localparam logic [10:0] DIGITAL_HIGH  = 11'd1812;
    localparam logic [11:0] PULSE_OFFSET  = 12'd880;
    localparam logic [4:0]  CH_DIG0       = 5'd16;
    localparam logic [4:0]  CH_LAST       = 5'd17;
    localparam int FLAG_BIT_CH16          = 0;
    localparam int FLAG_BIT_CH17          = 1;
    localparam int FLAG_BIT_FAILSAFE      = 3;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] time_us;
    } t_in;

    typedef struct packed {
        logic [4:0]  channel_index;
        logic [10:0] raw_value;
        logic [11:0] pulse_us;
        logic        failsafe;
        logic        last;
    } t_out;

    // Pulse width: (raw * 5 >> 3) + 880, raw * 5 as shift and add.
    function automatic logic [11:0] pulse_of(input logic [10:0] raw);
        logic [13:0] times5;
        times5 = {1'b0, raw, 2'b00} + {3'b000, raw};
        return {1'b0, times5[13:3]} + PULSE_OFFSET;
    endfunction

endpackage

// ===== hdl/sbus_frame_receiver.sv =====
// Serial RC frame receiver: byte framing with gap resync and channel unpacking.
// Throughput: one byte transfer per cycle while input ready is high; one result transfer
// per cycle while the output is taken. The final byte transfer loads the burst registers,
// then channel 0 enters the output register once it is free and the 18 results follow.
// Input ready drops only while the frame position sits at the final byte and the previous
// burst is still unpacking. Reset (synchronous, active low) clears position, start time,
// burst and output valid, and sets the gap timeout to 3500 us.
module sbus_frame_receiver (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sbusfr_pkg::t_in   i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sbusfr_pkg::t_out  o_out
);

    // Framing state
    logic [15:0]                   r_gap;
    logic [sbusfr_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [31:0]                   r_start, n_start;
    logic [7:0]                    r_frame [1:sbusfr_pkg::FLAG_POS];

    // Burst state: payload bits of the finished frame, shifted one channel per result
    logic [sbusfr_pkg::DATA_W-1:0] r_bits, n_bits;
    logic [7:0]                    r_flags, n_flags;
    logic [4:0]                    r_ch, n_ch;
    logic                          r_busy, n_busy;

    // Output register
    logic                          r_out_valid, n_out_valid;
    sbusfr_pkg::t_out              r_out, n_out;

    logic                          in_xfer;
    logic                          advance;
    logic [31:0]                   diff;
    logic                          resync;
    logic [sbusfr_pkg::POS_W-1:0]  pos0;
    logic                          frame_done;
    logic                          store_en;
    logic [sbusfr_pkg::DATA_W-1:0] frame_bits;
    logic [10:0]                   raw;

    // Hold off the final byte of a frame until the previous burst has gone out.
    assign o_in_ready = !(r_busy && (r_pos == sbusfr_pkg::LAST_POS));
    assign in_xfer    = i_in_valid && o_in_ready;
    assign advance    = r_busy && (!r_out_valid || i_out_ready);

    // Gap check: signed difference from frame start, negative never resyncs.
    assign diff   = i_in.time_us - r_start;
    assign resync = !diff[31] && (diff > {16'd0, r_gap});
    assign pos0   = resync ? '0 : r_pos;

    // Bytes 1..23 are the only ones ever read; header and end byte need no storage.
    assign store_en   = in_xfer && (pos0 != '0) && (pos0 != sbusfr_pkg::LAST_POS);
    assign frame_done = in_xfer && (pos0 == sbusfr_pkg::LAST_POS);

    always_comb begin
        for (int k = 0; k < sbusfr_pkg::DATA_BYTES; k++) begin
            frame_bits[8*k +: 8] = r_frame[k + 1];
        end
    end

    // Next framing state
    always_comb begin
        n_pos   = r_pos;
        n_start = r_start;
        if (in_xfer) begin
            if (pos0 == '0) begin
                if (i_in.rx_byte == sbusfr_pkg::HEADER_BYTE) begin
                    n_start = i_in.time_us;
                    n_pos   = sbusfr_pkg::POS_W'(1);
                end else begin
                    n_pos   = '0;
                end
            end else if (pos0 == sbusfr_pkg::LAST_POS) begin
                n_pos = '0;
            end else begin
                n_pos = pos0 + sbusfr_pkg::POS_W'(1);
            end
        end
    end

    // Raw value of the channel at the head of the burst
    always_comb begin
        if (r_ch < sbusfr_pkg::CH_DIG0) begin
            raw = r_bits[sbusfr_pkg::CH_BITS-1:0];
        end else if (r_ch == sbusfr_pkg::CH_DIG0) begin
            raw = r_flags[sbusfr_pkg::FLAG_BIT_CH16] ? sbusfr_pkg::DIGITAL_HIGH
                                                     : sbusfr_pkg::DIGITAL_LOW;
        end else begin
            raw = r_flags[sbusfr_pkg::FLAG_BIT_CH17] ? sbusfr_pkg::DIGITAL_HIGH
                                                     : sbusfr_pkg::DIGITAL_LOW;
        end
    end

    // Burst and output register
    always_comb begin
        n_bits      = r_bits;
        n_flags     = r_flags;
        n_ch        = r_ch;
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (advance) begin
            n_out.channel_index = r_ch;
            n_out.raw_value     = raw;
            n_out.pulse_us      = sbusfr_pkg::pulse_of(raw);
            n_out.failsafe      = r_flags[sbusfr_pkg::FLAG_BIT_FAILSAFE];
            n_out.last          = (r_ch == sbusfr_pkg::CH_LAST);
            n_out_valid         = 1'b1;
            n_bits              = r_bits >> sbusfr_pkg::CH_BITS;
            n_ch                = r_ch + 5'd1;
            if (r_ch == sbusfr_pkg::CH_LAST) begin
                n_busy = 1'b0;
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        // Load a finished frame; ready guarantees the burst is idle here.
        if (frame_done) begin
            n_bits  = frame_bits;
            n_flags = r_frame[sbusfr_pkg::FLAG_POS];
            n_ch    = '0;
            n_busy  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap       <= sbusfr_pkg::GAP_RESET;
            r_pos       <= '0;
            r_start     <= '0;
            r_ch        <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gap <= i_cfg_data;
            end
            r_pos       <= n_pos;
            r_start     <= n_start;
            r_ch        <= n_ch;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_frame[pos0] <= i_in.rx_byte;
        end
        r_bits  <= n_bits;
        r_flags <= n_flags;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // End of frame marker sits on the last digital channel only.
    a_last_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.last == (o_out.channel_index == sbusfr_pkg::CH_LAST)))
        else $error("last flag does not match channel index");

    // A new burst starts at channel zero.
    a_burst_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> (r_ch == '0))
        else $error("burst started at nonzero channel");

    // Frame position never passes the end byte.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= sbusfr_pkg::LAST_POS)
        else $error("byte position out of range");

    // Pulse width never falls below its offset.
    a_pulse_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.pulse_us >= sbusfr_pkg::PULSE_OFFSET))
        else $error("pulse width below offset");

endmodule

// ===== sim/sbusfr_frame_checker.sv =====
// Frame decode predictor and channel result scoreboard for the serial RC frame receiver.
`timescale 1ns / 1ps
module sbusfr_frame_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  sbusfr_pkg::t_in   i_in,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  sbusfr_pkg::t_out  i_out,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_results_seen,
    output int                o_frames_decoded
);

    localparam int REPORT_LIMIT = 10;

    logic [15:0]                  gap_us;
    logic [sbusfr_pkg::POS_W-1:0] byte_pos;
    logic [31:0]                  start_us;
    logic [7:0]                   frame_mem [sbusfr_pkg::FRAME_BYTES];
    sbusfr_pkg::t_out             channel_q [$];
    int                           fails  = 0;
    int                           seen   = 0;
    int                           frames = 0;

    // Advance the frame position by one byte; on the final byte queue all channels.
    task automatic decode_byte(input logic [7:0] rx, input logic [31:0] stamp);
        logic [31:0]                          diff;
        logic [8*sbusfr_pkg::FRAME_BYTES-1:0] frame_bits;
        logic [7:0]                           flags;
        logic [10:0]                          raw;
        sbusfr_pkg::t_out                     res;
        diff = stamp - start_us;
        // resync only on a positive gap beyond the limit; a negative gap never counts
        if (!diff[31] && diff > {16'd0, gap_us})
            byte_pos = '0;
        if (byte_pos >= sbusfr_pkg::FRAME_BYTES)
            byte_pos = '0;
        frame_mem[byte_pos] = rx;
        if (byte_pos != 0 || rx == sbusfr_pkg::HEADER_BYTE) begin
            if (byte_pos == 0)
                start_us = stamp;
            byte_pos = byte_pos + 1'b1;
            if (byte_pos == sbusfr_pkg::FRAME_BYTES) begin
                byte_pos = '0;
                frames++;
                for (int i = 0; i < sbusfr_pkg::FRAME_BYTES; i++)
                    frame_bits[8*i +: 8] = frame_mem[i];
                flags = frame_mem[sbusfr_pkg::FLAG_POS];
                for (int ch = 0; ch <= sbusfr_pkg::CH_LAST; ch++) begin
                    if (ch < sbusfr_pkg::NUM_ANALOG)
                        raw = frame_bits[8 + sbusfr_pkg::CH_BITS*ch +: sbusfr_pkg::CH_BITS];
                    else if (ch == sbusfr_pkg::CH_DIG0)
                        raw = flags[sbusfr_pkg::FLAG_BIT_CH16] ? sbusfr_pkg::DIGITAL_HIGH
                                                              : sbusfr_pkg::DIGITAL_LOW;
                    else
                        raw = flags[sbusfr_pkg::FLAG_BIT_CH17] ? sbusfr_pkg::DIGITAL_HIGH
                                                              : sbusfr_pkg::DIGITAL_LOW;
                    res.channel_index = 5'(ch);
                    res.raw_value     = raw;
                    res.pulse_us      = 12'((32'(raw) * 5) >> 3) + sbusfr_pkg::PULSE_OFFSET;
                    res.failsafe      = flags[sbusfr_pkg::FLAG_BIT_FAILSAFE];
                    res.last          = (ch == sbusfr_pkg::CH_LAST);
                    channel_q.push_back(res);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        sbusfr_pkg::t_out want;
        if (!i_rst_n) begin
            gap_us   = sbusfr_pkg::GAP_RESET;
            byte_pos = '0;
            start_us = '0;
            channel_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen++;
                if (channel_q.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display({"[%0t] unexpected result: ",
                                  "ch=%0d raw=%0d pulse=%0d fs=%0b last=%0b"},
                                 $time, i_out.channel_index, i_out.raw_value,
                                 i_out.pulse_us, i_out.failsafe, i_out.last);
                end else begin
                    want = channel_q.pop_front();
                    if (i_out !== want) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display("[%0t] result %0d mismatch", $time, seen);
                            $display("    expected ch=%0d raw=%0d pulse=%0d fs=%0b last=%0b",
                                     want.channel_index, want.raw_value, want.pulse_us,
                                     want.failsafe, want.last);
                            $display("    actual   ch=%0d raw=%0d pulse=%0d fs=%0b last=%0b",
                                     i_out.channel_index, i_out.raw_value, i_out.pulse_us,
                                     i_out.failsafe, i_out.last);
                        end
                    end
                end
            end
            if (i_cfg_we)
                gap_us = i_cfg_data;
            if (i_in_valid && i_in_ready)
                decode_byte(i_in.rx_byte, i_in.time_us);
        end
        o_fail_count     <= fails;
        o_pending        <= channel_q.size();
        o_results_seen   <= seen;
        o_frames_decoded <= frames;
    end

endmodule

// ===== sim/tb_sbus_frame_receiver.sv =====
// Testbench top: byte stimulus, handshake pacing and verdict for the serial RC frame receiver.
`timescale 1ns / 1ps
module tb_sbus_frame_receiver;

    // Data fill of the channel bytes of one frame.
    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } t_fill;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [15:0]      i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    sbusfr_pkg::t_in  i_in;
    logic             o_out_valid;
    logic             i_out_ready;
    sbusfr_pkg::t_out o_out;

    int          fail_count;
    int          pending;
    int          results_seen;
    int          frames_decoded;

    // Pacing knobs, percent of cycles: sender idle and receiver stall.
    int          idle_pct  = 0;
    int          stall_pct = 0;
    // Mirror of the programmed gap limit, used only to shape timestamps.
    logic [15:0] gap_us    = sbusfr_pkg::GAP_RESET;
    // Running timestamp carried between frames.
    logic [31:0] now_us    = '0;
    int          bytes_sent = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sbus_frame_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    sbusfr_frame_checker frame_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_in             (i_in),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_out            (o_out),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_results_seen   (results_seen),
        .o_frames_decoded (frames_decoded)
    );

    // Receiver side: drop ready at random according to the current stall rate.
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= stall_pct);

    // Move one byte across the input channel. Call right after a rising edge.
    // Valid stays high into the next call when no idle cycle is drawn, so a
    // back-to-back stream never sees valid lowered and raised in one step.
    task automatic send_byte(input logic [7:0] rx, input logic [31:0] stamp);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= {rx, stamp};
        @(posedge i_clk);
        // ready sampled here is the value seen by the block at this edge
        while (!o_in_ready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    // Hold the input idle until every queued channel has come out, then let the
    // block settle for the given number of extra cycles.
    task automatic drain(input int extra);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // Program the gap limit; only ever called with the block idle.
    task automatic write_gap(input logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        gap_us = value;
    endtask

    // Send one complete frame whose bytes all land within the gap limit of
    // its header, starting at the running timestamp.
    task automatic send_frame(input t_fill fill);
        logic [7:0]  b;
        logic [31:0] t;
        int          step_max;
        // 24 forward steps of at most this size never exceed the limit
        step_max = gap_us / 24;
        t = now_us;
        send_byte(sbusfr_pkg::HEADER_BYTE, t);
        for (int i = 1; i < sbusfr_pkg::FRAME_BYTES; i++) begin
            // now and then step back in time: a negative gap must not resync
            if ($urandom_range(9) == 0)
                t = t - $urandom_range(1000, 1);
            else
                t = t + $urandom_range(step_max);
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom);
            endcase
            // flag byte and end byte always random
            if (i >= sbusfr_pkg::FLAG_POS)
                b = 8'($urandom);
            send_byte(b, t);
        end
        now_us = t + $urandom_range(step_max);
    endtask

    // One random phase: new gap limit and pacing, an optional lead-in of line
    // noise or a cut-off frame, then one or more good frames.
    task automatic run_phase(input logic [15:0] gap, input int sender_idle,
                             input int recv_stall, input int frame_count,
                             input t_fill first_fill);
        logic [7:0] b;
        int         n;
        drain(10);
        write_gap(gap);
        idle_pct  = sender_idle;
        stall_pct = recv_stall;
        // fresh timestamp base: the gap to the last frame start may be negative
        now_us    = $urandom;
        case ($urandom_range(2))
            0: begin
                // stray bytes at frame position zero; never the header
                n = $urandom_range(3, 1);
                for (int i = 0; i < n; i++) begin
                    b = 8'($urandom);
                    if (b == sbusfr_pkg::HEADER_BYTE)
                        b = ~b;
                    send_byte(b, now_us + $urandom_range(50));
                end
            end
            1: begin
                // header plus a few bytes, then silence past the limit
                send_byte(sbusfr_pkg::HEADER_BYTE, now_us);
                n = $urandom_range(6, 1);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom), now_us + $urandom_range(gap_us / 24));
                now_us = now_us + gap_us + 1 + $urandom_range(1000);
            end
            default: ;
        endcase
        for (int f = 0; f < frame_count; f++)
            send_frame(f == 0 ? first_fill : t_fill'($urandom_range(2)));
    endtask

    initial begin : stimulus
        logic [31:0] t0;
        logic [31:0] t;
        logic [7:0]  b;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset gap limit, no idling.
        // Wrong headers at position zero, with the timestamp extremes.
        send_byte(8'h00, 32'h0000_0000);
        send_byte(8'hFF, 32'hFFFF_FFFF);
        // Header just below the wrap, then the next header one past the limit:
        // it must resync instead of landing as data at position one.
        send_byte(sbusfr_pkg::HEADER_BYTE, 32'hFFFF_F000);
        t0 = 32'hFFFF_F000 + sbusfr_pkg::GAP_RESET + 1;
        send_byte(sbusfr_pkg::HEADER_BYTE, t0);
        // Frame of all-ones channel data that crosses the timestamp wrap, with
        // one byte earlier than the header and the end byte exactly at the limit.
        for (int i = 1; i < sbusfr_pkg::FRAME_BYTES; i++) begin
            if (i == 1)
                t = t0 - 100;
            else if (i == sbusfr_pkg::FRAME_BYTES - 1)
                t = t0 + sbusfr_pkg::GAP_RESET;
            else
                t = t0 + 100 * i;
            if (i < sbusfr_pkg::FLAG_POS)
                b = 8'hFF;
            else if (i == sbusfr_pkg::FLAG_POS)
                b = 8'((1 << sbusfr_pkg::FLAG_BIT_CH16) |
                       (1 << sbusfr_pkg::FLAG_BIT_CH17) |
                       (1 << sbusfr_pkg::FLAG_BIT_FAILSAFE));
            else
                b = 8'h00;
            send_byte(b, t);
        end

        // Random phases: zero limit with an idle sender, widest limit with a
        // stalling receiver, small limit with both.
        run_phase(16'd0, 61, 0, 1, FILL_ZERO);
        run_phase(16'hFFFF, 0, 61, 1, FILL_RANDOM);
        run_phase(16'($urandom_range(600, 24)), 11, 11, 1, FILL_ONES);

        drain(20);
        $display("Covered %0d byte transfers, %0d frames decoded, %0d channel results checked",
                 bytes_sent, frames_decoded, results_seen);
        $display("over gap limits from 0 to 65535 us and four handshake pacing patterns");
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
